[hw/rtl/cce_pkg.sv]
package cce_pkg;

	// widths of the request, result and configuration fields
	localparam int IdxW     = 10;
	localparam int BlkW     = 9;
	localparam int SymW     = 2;
	localparam int BundW    = 9;
	localparam int CceW     = 8;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 10;

	localparam int MaxRegsDefault = 810;

	// register indexes of the configuration port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_MODE    = 3'd0,
		CFG_NREGS   = 3'd1,
		CFG_SYMBOLS = 3'd2,
		CFG_BUNDLE  = 3'd3,
		CFG_ROWS    = 3'd4,
		CFG_SHIFT   = 3'd5
	} cfg_reg_t;

	// supported bundle and interleaver sizes
	localparam logic [2:0] Size2 = 3'd2;
	localparam logic [2:0] Size3 = 3'd3;
	localparam logic [2:0] Size6 = 3'd6;

	// floor(x / 3) == (x * Recip3) >> 11 for every x below 2048
	localparam logic [9:0] Recip3 = 10'd683;

endpackage

[hw/rtl/cce_if.sv]
interface cce_in_if;
	logic                      valid;
	logic                      ready;
	logic [cce_pkg::IdxW-1:0]  reg_index;

	modport source (output valid, output reg_index, input ready);
	modport sink   (input valid, input reg_index, output ready);
endinterface

interface cce_out_if;
	logic                      valid;
	logic                      ready;
	logic [cce_pkg::BlkW-1:0]  block_index;
	logic [cce_pkg::SymW-1:0]  symbol_index;
	logic [cce_pkg::BundW-1:0] bundle_number;
	logic [cce_pkg::BundW-1:0] mapped_bundle;
	logic [cce_pkg::CceW-1:0]  cce_number;
	logic                      out_of_range;

	modport source (output valid, output block_index, output symbol_index,
		output bundle_number, output mapped_bundle, output cce_number,
		output out_of_range, input ready);
	modport sink   (input valid, input block_index, input symbol_index,
		input bundle_number, input mapped_bundle, input cce_number,
		input out_of_range, output ready);
endinterface

interface cce_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [cce_pkg::CfgIdxW-1:0]  index;
	logic [cce_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/coreset_cce_reg_interleaver.sv]
// coreset cce-to-reg mapper, one reg index in, one mapping result out
//
// channels: req carries a reg index, rsp returns block, symbol, bundle,
// mapped bundle, cce and an out-of-range flag; a request is taken at a
// clock edge with valid and ready both high, likewise a result
// cfg is a write-only register port, always ready; a write with an index
// past the register list is dropped; the user must make writes only while
// idle, which the block itself does not enforce
// throughput: one request per cycle, sustained while rsp is not stalled
// pipeline: seven register stages, set by the two reciprocal multiplies
// (divide by three) and the interleaver position add and wrap
// a side chain of registers derives the per-set constants (bundle count,
// column count, shift modulo bundle count) from the config registers; each
// stage of the request pipeline only reads chain values that are already
// settled by the time a request reaches it
//
// stall: a stage holds while the stage after it is full and held, empty
// stages fill in, so nothing is dropped or repeated; req.ready falls only
// when all stages are full and rsp is not taken
// reset: arst_n clears the pipeline valid bits and loads the config
// registers with their defaults (non-interleaved, 36 regs, 3 symbols)
module coreset_cce_reg_interleaver #(
	parameter int MAX_REGS = cce_pkg::MaxRegsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	cce_cfg_if.sink     cfg,
	cce_in_if.sink      req,
	cce_out_if.source   rsp
);

	localparam logic [10:0] MaxRegsW = 11'(MAX_REGS);

	// configuration registers
	logic       mode_q;
	logic [9:0] nregs_q;
	logic [1:0] symbols_q;
	logic [2:0] bundle_q;
	logic [2:0] rows_q;
	logic [8:0] shift_q;

	// derived per-set constants
	logic [9:0] n_q;       // reg count after clamp
	logic [8:0] n3_q;      // n / 3
	logic [2:0] l_q;       // legal bundle size
	logic [2:0] r_q;       // legal interleaver size
	logic [1:0] symb_q;    // symbol count, zero read as one
	logic [8:0] nb_q;      // bundles in the set, n / l
	logic [8:0] nb3_q;     // nb / 3
	logic [7:0] cols_q;    // interleaver columns, nb / r
	logic [8:0] rem_a_q;   // shift modulo nb, partial remainders
	logic [8:0] rem_b_q;
	logic [8:0] shmod_q;

	logic [9:0]  n_eff;
	logic [19:0] n_prod;
	logic [19:0] nb_prod;

	function automatic logic [2:0] legal_size(input logic [2:0] v);
		logic [2:0] s;
		case (v)
			cce_pkg::Size2, cce_pkg::Size3, cce_pkg::Size6: s = v;
			default: s = cce_pkg::Size6;
		endcase
		return s;
	endfunction

	// one restoring step of a remainder, rem stays below d
	function automatic logic [8:0] mod_step(input logic [8:0] rem, input logic b,
		input logic [8:0] d);
		logic [9:0] t;
		t = {rem, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[8:0];
	endfunction

	function automatic logic [8:0] mod_step3(input logic [8:0] rem, input logic [2:0] b,
		input logic [8:0] d);
		return mod_step(mod_step(mod_step(rem, b[2], d), b[1], d), b[0], d);
	endfunction

	// config write port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			nregs_q   <= 10'd36;
			symbols_q <= 2'd3;
			bundle_q  <= cce_pkg::Size6;
			rows_q    <= cce_pkg::Size6;
			shift_q   <= 9'd0;
		end else if (cfg.valid) begin
			case (cfg.index)
				cce_pkg::CFG_MODE:    mode_q    <= cfg.data[0];
				cce_pkg::CFG_NREGS:   nregs_q   <= cfg.data;
				cce_pkg::CFG_SYMBOLS: symbols_q <= cfg.data[1:0];
				cce_pkg::CFG_BUNDLE:  bundle_q  <= cfg.data[2:0];
				cce_pkg::CFG_ROWS:    rows_q    <= cfg.data[2:0];
				cce_pkg::CFG_SHIFT:   shift_q   <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// constant chain: step 1 clamp and legalize, step 2 bundle count,
	// steps 3 to 5 column count and shift remainder, three bits a step
	assign n_eff   = ({1'b0, nregs_q} > MaxRegsW) ? MaxRegsW[9:0] : nregs_q;
	assign n_prod  = 20'(n_eff) * 20'(cce_pkg::Recip3);
	assign nb_prod = 20'(nb_q) * 20'(cce_pkg::Recip3);

	always_ff @(posedge clk) begin
		n_q    <= n_eff;
		n3_q   <= n_prod[19:11];
		l_q    <= legal_size(bundle_q);
		r_q    <= legal_size(rows_q);
		symb_q <= (symbols_q == 2'd0) ? 2'd1 : symbols_q;

		case (l_q)
			cce_pkg::Size2: nb_q <= n_q[9:1];
			cce_pkg::Size3: nb_q <= n3_q;
			default:        nb_q <= {1'b0, n3_q[8:1]};
		endcase

		nb3_q   <= nb_prod[19:11];
		rem_a_q <= mod_step3(9'd0, shift_q[8:6], nb_q);

		case (r_q)
			cce_pkg::Size2: cols_q <= nb_q[8:1];
			cce_pkg::Size3: cols_q <= nb3_q[7:0];
			default:        cols_q <= nb3_q[8:1];
		endcase
		rem_b_q <= mod_step3(rem_a_q, shift_q[5:3], nb_q);

		shmod_q <= mod_step3(rem_b_q, shift_q[2:0], nb_q);
	end

	// request pipeline, stage enables collapse bubbles
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || rsp.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage payloads
	logic [9:0] idx_s1;
	logic [9:0] idx_s2;
	logic [8:0] q3_s2;
	logic       oor_s2, oor_s3, oor_s4, oor_s5, oor_s6;
	logic [8:0] blk_s3, blk_s4, blk_s5, blk_s6;
	logic [1:0] sym_s3, sym_s4, sym_s5, sym_s6;
	logic [8:0] bnum_s3, bnum_s4, bnum_s5, bnum_s6;
	logic [7:0] bq3_s4;
	logic [7:0] cce_s4, cce_s5, cce_s6;
	logic [7:0] q_s5;
	logic [2:0] row_s5;
	logic [7:0] col_s6;
	logic [9:0] rc_s6;

	logic [8:0] blk_s7;
	logic [1:0] sym_s7;
	logic [8:0] bnum_s7;
	logic [8:0] mapped_s7;
	logic [7:0] cce_s7;
	logic       oor_s7;

	logic [19:0] idx_prod;
	logic [9:0]  blk_full;
	logic [9:0]  three_q3;
	logic [1:0]  sym_c;
	logic [8:0]  bnum_c;
	logic [18:0] bnum_prod;
	logic [7:0]  cce_c;
	logic [7:0]  q_c;
	logic [10:0] qr_c;
	logic [9:0]  a_c;
	logic [9:0]  t_c;
	logic [9:0]  m_c;
	logic [8:0]  mapped_c;

	// stage 2: divide index by three
	assign idx_prod = 20'(idx_s1) * 20'(cce_pkg::Recip3);

	// stage 3: block, symbol and bundle number
	assign three_q3 = 10'({q3_s2, 1'b0}) + 10'(q3_s2);

	always_comb begin
		case (symb_q)
			2'd1: begin
				blk_full = idx_s2;
				sym_c    = 2'd0;
			end
			2'd2: begin
				blk_full = {1'b0, idx_s2[9:1]};
				sym_c    = {1'b0, idx_s2[0]};
			end
			default: begin
				blk_full = {1'b0, q3_s2};
				sym_c    = 2'(idx_s2 - three_q3);
			end
		endcase

		if (mode_q) begin
			case (l_q)
				cce_pkg::Size2: bnum_c = idx_s2[9:1];
				cce_pkg::Size3: bnum_c = q3_s2;
				default:        bnum_c = {1'b0, q3_s2[8:1]};
			endcase
		end else begin
			bnum_c = {1'b0, q3_s2[8:1]};
		end
	end

	// stage 4: bundle number by three, owning cce
	assign bnum_prod = 19'(bnum_s3) * 19'(cce_pkg::Recip3);

	always_comb begin
		if (mode_q) begin
			case (l_q)
				cce_pkg::Size2: cce_c = bnum_prod[18:11];
				cce_pkg::Size3: cce_c = bnum_s3[8:1];
				default:        cce_c = bnum_s3[7:0];
			endcase
		end else begin
			cce_c = bnum_s3[7:0];
		end
	end

	// stage 5: interleaver row and column quotient
	always_comb begin
		case (r_q)
			cce_pkg::Size2: q_c = bnum_s4[8:1];
			cce_pkg::Size3: q_c = bq3_s4;
			default:        q_c = {1'b0, bq3_s4[7:1]};
		endcase
	end

	assign qr_c = 11'(q_c) * 11'(r_q);

	// stage 7: position, wrapped once since both terms are below nb
	assign a_c = rc_s6 + 10'(col_s6);
	assign t_c = a_c + 10'(shmod_q);
	assign m_c = (t_c >= 10'(nb_q)) ? (t_c - 10'(nb_q)) : t_c;

	always_comb begin
		if (!mode_q) begin
			mapped_c = bnum_s6;
		end else if (nb_q == 9'd0) begin
			mapped_c = 9'd0;
		end else begin
			mapped_c = m_c[8:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			idx_s1 <= req.reg_index;
		end
		if (en2) begin
			idx_s2 <= idx_s1;
			q3_s2  <= idx_prod[19:11];
			oor_s2 <= (idx_s1 >= n_q);
		end
		if (en3) begin
			oor_s3  <= oor_s2;
			blk_s3  <= blk_full[8:0];
			sym_s3  <= sym_c;
			bnum_s3 <= bnum_c;
		end
		if (en4) begin
			oor_s4  <= oor_s3;
			blk_s4  <= blk_s3;
			sym_s4  <= sym_s3;
			bnum_s4 <= bnum_s3;
			bq3_s4  <= bnum_prod[18:11];
			cce_s4  <= cce_c;
		end
		if (en5) begin
			oor_s5  <= oor_s4;
			blk_s5  <= blk_s4;
			sym_s5  <= sym_s4;
			bnum_s5 <= bnum_s4;
			cce_s5  <= cce_s4;
			q_s5    <= q_c;
			row_s5  <= 3'(11'(bnum_s4) - qr_c);
		end
		if (en6) begin
			oor_s6  <= oor_s5;
			blk_s6  <= blk_s5;
			sym_s6  <= sym_s5;
			bnum_s6 <= bnum_s5;
			cce_s6  <= cce_s5;
			// column quotient never passes cols, so one subtract wraps it
			if (cols_q == 8'd0) begin
				col_s6 <= 8'd0;
			end else if (q_s5 >= cols_q) begin
				col_s6 <= q_s5 - cols_q;
			end else begin
				col_s6 <= q_s5;
			end
			rc_s6 <= 10'(row_s5) * 10'(cols_q);
		end
		if (en7) begin
			oor_s7 <= oor_s6;
			if (oor_s6) begin
				blk_s7    <= 9'd0;
				sym_s7    <= 2'd0;
				bnum_s7   <= 9'd0;
				mapped_s7 <= 9'd0;
				cce_s7    <= 8'd0;
			end else begin
				blk_s7    <= blk_s6;
				sym_s7    <= sym_s6;
				bnum_s7   <= bnum_s6;
				mapped_s7 <= mapped_c;
				cce_s7    <= cce_s6;
			end
		end
	end

	assign rsp.valid         = v_s7;
	assign rsp.block_index   = blk_s7;
	assign rsp.symbol_index  = sym_s7;
	assign rsp.bundle_number = bnum_s7;
	assign rsp.mapped_bundle = mapped_s7;
	assign rsp.cce_number    = cce_s7;
	assign rsp.out_of_range  = oor_s7;

	// an out-of-range result carries only the flag
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.out_of_range |-> rsp.block_index == 9'd0 &&
		rsp.symbol_index == 2'd0 && rsp.bundle_number == 9'd0 &&
		rsp.mapped_bundle == 9'd0 && rsp.cce_number == 8'd0)
		else $error("out-of-range result with nonzero fields");

	// back pressure only comes from a full pipe behind a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid && !rsp.ready && v_s1 && v_s6)
		else $error("request side stalled with room in the pipeline");

	// a taken request occupies the first stage
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted request lost at the first stage");

	// symbol position never reaches three
	a_sym: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.symbol_index != 2'd3)
		else $error("symbol index out of range");

endmodule
